[rtl/iets_pkg.sv]
// Shared types and codes for the I2C EEPROM transfer sequencer.
`timescale 1ns / 1ps
package iets_pkg;

	typedef enum logic [2:0] {
		OP_WR_REQ  = 3'd0,
		OP_WR_DATA = 3'd1,
		OP_RD_REQ  = 3'd2,
		OP_ACK     = 3'd3,
		OP_RD_DATA = 3'd4
	} op_code_t;

	typedef enum logic [2:0] {
		K_START   = 3'd0,
		K_SEND    = 3'd1,
		K_STOP    = 3'd2,
		K_RACK    = 3'd3,
		K_RNACK   = 3'd4,
		K_RECOVER = 3'd5,
		K_DATA    = 3'd6,
		K_DONE    = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ADDR_ERR = 2'd1,
		ST_BUS_ERR  = 2'd2
	} status_t;

	localparam logic [0:0] REG_BASE    = 1'd0;
	localparam logic [0:0] REG_TIMEOUT = 1'd1;

	localparam logic [6:0] BASE_RESET    = 7'd80;
	localparam logic [7:0] TIMEOUT_RESET = 8'd5;
	localparam logic [2:0] BLOCK_BIT     = 3'h4;

	typedef struct packed {
		logic [2:0]  op;
		logic [16:0] start_addr;
		logic [17:0] length;
		logic [7:0]  data_byte;
		logic        ack;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  bus_byte;
		logic [1:0]  status;
		logic [17:0] count;
		logic        last;
	} out_item_t;

	// Up to four results per input travel together between front and back.
	typedef struct packed {
		logic [2:0]  n;
		out_item_t   r0;
		out_item_t   r1;
		out_item_t   r2;
		out_item_t   r3;
	} group_t;

	typedef struct packed {
		logic can_take;
	} link_t;

endpackage

[rtl/iets_front.sv]
// Front: sequencer state machine; turns each accepted item into a group of results.
`timescale 1ns / 1ps
module iets_front #(
	parameter int PAGE_BYTES   = 128,
	parameter int BLOCK_BYTES  = 65536,
	parameter int DEVICE_BYTES = 131072,
	parameter int POLLS_PER_MS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [7:0]        cfg_data,
	input  logic              take,
	input  iets_pkg::in_item_t item,
	output iets_pkg::group_t  grp
);
	localparam int PW = $clog2(PAGE_BYTES);

	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_DEV     = 9'b000000010,
		PH_AHI     = 9'b000000100,
		PH_ALO     = 9'b000001000,
		PH_WR      = 9'b000010000,
		PH_WR_ACK  = 9'b000100000,
		PH_POLL    = 9'b001000000,
		PH_RD_DEV  = 9'b010000000,
		PH_RD      = 9'b100000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        is_read_q, is_read_d;
	logic [16:0] addr_q, addr_d;
	logic [17:0] rem_q, rem_d;
	logic [17:0] chunk_q, chunk_d;
	logic [10:0] polls_q, polls_d;
	logic [17:0] done_q, done_d;
	logic [6:0]  base_q;
	logic [7:0]  tmo_q;
	logic [10:0] poll_lim_q;

	iets_pkg::out_item_t r [4];
	logic [2:0] n;

	function automatic iets_pkg::out_item_t mk(iets_pkg::kind_t k, logic [7:0] b,
		logic [1:0] s, logic [17:0] c);
		iets_pkg::out_item_t o;
		o.kind = k; o.bus_byte = b; o.status = s; o.count = c; o.last = 1'b0;
		return o;
	endfunction

	function automatic logic [7:0] dev_byte(logic [6:0] base, logic [16:0] a, logic rd);
		logic [6:0] d;
		d = base;
		if (32'(a) >= BLOCK_BYTES) d = d | 7'(iets_pkg::BLOCK_BIT);
		return {d, rd};
	endfunction

	// Chunk length from a start address: page/block bounded for writes, block only for reads.
	function automatic logic [17:0] chunk_len(logic [16:0] a, logic [17:0] rem, logic rd);
		logic [18:0] bound, page, c;
		bound = (32'(a) < BLOCK_BYTES) ? 19'(BLOCK_BYTES) : 19'(DEVICE_BYTES);
		page  = ((19'(a) >> PW) + 19'd1) << PW;
		if (!rd && page < bound) bound = page;
		c = bound - 19'(a);
		if (c > 19'(rem)) c = 19'(rem);
		return c[17:0];
	endfunction

	always_comb begin
		logic [18:0] sum;
		logic [17:0] ck;
		logic [10:0] pn;
		phase_d = phase_q; is_read_d = is_read_q; addr_d = addr_q; rem_d = rem_q;
		chunk_d = chunk_q; polls_d = polls_q; done_d = done_q;
		for (int i = 0; i < 4; i++) r[i] = mk(iets_pkg::K_START, 8'd0, 2'd0, 18'd0);
		n = 3'd0;
		sum = 19'(item.start_addr) + 19'(item.length);
		ck = chunk_len(addr_q, rem_q, is_read_q);
		pn = polls_q + 11'd1;
		unique case (phase_q)
			PH_IDLE: begin
				if (item.op == iets_pkg::OP_WR_REQ || item.op == iets_pkg::OP_RD_REQ) begin
					is_read_d = (item.op == iets_pkg::OP_RD_REQ);
					done_d = 18'd0;
					if (item.length == 18'd0 || 32'(sum) > DEVICE_BYTES) begin
						r[0] = mk(iets_pkg::K_DONE, 8'd0, iets_pkg::ST_ADDR_ERR, 18'd0);
						n = 3'd1;
						phase_d = PH_IDLE;
					end else begin
						addr_d = item.start_addr;
						rem_d = item.length;
						chunk_d = chunk_len(item.start_addr, item.length, is_read_d);
						r[0] = mk(iets_pkg::K_START, 8'd0, 2'd0, 18'd0);
						r[1] = mk(iets_pkg::K_SEND, dev_byte(base_q, item.start_addr, 1'b0),
							2'd0, 18'd0);
						n = 3'd2;
						phase_d = PH_DEV;
					end
				end
			end
			PH_DEV, PH_AHI, PH_ALO, PH_RD_DEV: begin
				if (item.op == iets_pkg::OP_ACK) begin
					if (!item.ack) begin
						r[0] = mk(iets_pkg::K_STOP, 8'd0, 2'd0, 18'd0);
						r[1] = mk(iets_pkg::K_RECOVER, 8'd0, 2'd0, 18'd0);
						r[2] = mk(iets_pkg::K_DONE, 8'd0, iets_pkg::ST_BUS_ERR, done_q);
						n = 3'd3;
						phase_d = PH_IDLE;
					end else if (phase_q == PH_DEV) begin
						r[0] = mk(iets_pkg::K_SEND, addr_q[15:8], 2'd0, 18'd0);
						n = 3'd1;
						phase_d = PH_AHI;
					end else if (phase_q == PH_AHI) begin
						r[0] = mk(iets_pkg::K_SEND, addr_q[7:0], 2'd0, 18'd0);
						n = 3'd1;
						phase_d = PH_ALO;
					end else if (phase_q == PH_RD_DEV) begin
						r[0] = mk((chunk_q == 18'd1) ? iets_pkg::K_RNACK : iets_pkg::K_RACK,
							8'd0, 2'd0, 18'd0);
						n = 3'd1;
						phase_d = PH_RD;
					end else if (is_read_q) begin
						r[0] = mk(iets_pkg::K_START, 8'd0, 2'd0, 18'd0);
						r[1] = mk(iets_pkg::K_SEND, dev_byte(base_q, addr_q, 1'b1), 2'd0, 18'd0);
						n = 3'd2;
						phase_d = PH_RD_DEV;
					end else begin
						phase_d = PH_WR;
					end
				end
			end
			PH_WR: begin
				if (item.op == iets_pkg::OP_WR_DATA) begin
					r[0] = mk(iets_pkg::K_SEND, item.data_byte, 2'd0, 18'd0);
					n = 3'd1;
					chunk_d = chunk_q - 18'd1;
					rem_d = rem_q - 18'd1;
					addr_d = addr_q + 17'd1;
					phase_d = PH_WR_ACK;
				end
			end
			PH_WR_ACK: begin
				if (item.op == iets_pkg::OP_ACK) begin
					if (chunk_q != 18'd0) begin
						phase_d = PH_WR;
					end else begin
						r[0] = mk(iets_pkg::K_STOP, 8'd0, 2'd0, 18'd0);
						r[1] = mk(iets_pkg::K_START, 8'd0, 2'd0, 18'd0);
						r[2] = mk(iets_pkg::K_SEND, {base_q, 1'b0}, 2'd0, 18'd0);
						n = 3'd3;
						polls_d = 11'd0;
						phase_d = PH_POLL;
					end
				end
			end
			PH_POLL: begin
				if (item.op == iets_pkg::OP_ACK) begin
					r[0] = mk(iets_pkg::K_STOP, 8'd0, 2'd0, 18'd0);
					if (item.ack) begin
						if (rem_q == 18'd0) begin
							r[1] = mk(iets_pkg::K_DONE, 8'd0, iets_pkg::ST_OK, done_q);
							n = 3'd2;
							phase_d = PH_IDLE;
						end else begin
							chunk_d = ck;
							r[1] = mk(iets_pkg::K_START, 8'd0, 2'd0, 18'd0);
							r[2] = mk(iets_pkg::K_SEND, dev_byte(base_q, addr_q, 1'b0),
								2'd0, 18'd0);
							n = 3'd3;
							phase_d = PH_DEV;
						end
					end else begin
						polls_d = pn;
						if (pn >= poll_lim_q) begin
							r[1] = mk(iets_pkg::K_DONE, 8'd0, iets_pkg::ST_BUS_ERR, done_q);
							n = 3'd2;
							phase_d = PH_IDLE;
						end else begin
							r[1] = mk(iets_pkg::K_START, 8'd0, 2'd0, 18'd0);
							r[2] = mk(iets_pkg::K_SEND, {base_q, 1'b0}, 2'd0, 18'd0);
							n = 3'd3;
						end
					end
				end
			end
			PH_RD: begin
				if (item.op == iets_pkg::OP_RD_DATA) begin
					r[0] = mk(iets_pkg::K_DATA, item.data_byte, 2'd0, 18'd0);
					chunk_d = chunk_q - 18'd1;
					rem_d = rem_q - 18'd1;
					addr_d = addr_q + 17'd1;
					done_d = done_q + 18'd1;
					if (chunk_d != 18'd0) begin
						r[1] = mk((chunk_d == 18'd1) ? iets_pkg::K_RNACK : iets_pkg::K_RACK,
							8'd0, 2'd0, 18'd0);
						n = 3'd2;
					end else begin
						r[1] = mk(iets_pkg::K_STOP, 8'd0, 2'd0, 18'd0);
						if (rem_d == 18'd0) begin
							r[2] = mk(iets_pkg::K_DONE, 8'd0, iets_pkg::ST_OK, done_d);
							n = 3'd3;
							phase_d = PH_IDLE;
						end else begin
							chunk_d = chunk_len(addr_d, rem_d, 1'b1);
							r[2] = mk(iets_pkg::K_START, 8'd0, 2'd0, 18'd0);
							r[3] = mk(iets_pkg::K_SEND, dev_byte(base_q, addr_d, 1'b0),
								2'd0, 18'd0);
							n = 3'd4;
							phase_d = PH_DEV;
						end
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
		if (n != 3'd0) r[n[1:0] - 2'd1].last = 1'b1;
	end

	assign grp.n  = take ? n : 3'd0;
	assign grp.r0 = r[0];
	assign grp.r1 = r[1];
	assign grp.r2 = r[2];
	assign grp.r3 = r[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; is_read_q <= 1'b0; addr_q <= '0; rem_q <= '0;
			chunk_q <= '0; polls_q <= '0; done_q <= '0;
			base_q <= iets_pkg::BASE_RESET; tmo_q <= iets_pkg::TIMEOUT_RESET;
			poll_lim_q <= 11'(iets_pkg::TIMEOUT_RESET * POLLS_PER_MS);
		end else begin
			if (take) begin
				phase_q <= phase_d; is_read_q <= is_read_d; addr_q <= addr_d;
				rem_q <= rem_d; chunk_q <= chunk_d; polls_q <= polls_d; done_q <= done_d;
			end
			if (cfg_we && cfg_idx == iets_pkg::REG_BASE) base_q <= cfg_data[6:0];
			if (cfg_we && cfg_idx == iets_pkg::REG_TIMEOUT) begin
				tmo_q <= (cfg_data == 8'd0) ? 8'd1 : cfg_data;
			end
			poll_lim_q <= 11'(32'(tmo_q) * POLLS_PER_MS);
		end
	end

`ifndef NO_ASSERTIONS
	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(phase_q))
		else $error("phase not one-hot");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_RD && item.op == iets_pkg::OP_RD_DATA |-> n != 3'd0)
		else $error("read data gave no result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(phase_q))
		else $error("phase moved without an item");
`endif
endmodule

[rtl/iets_back.sv]
// Back: queue of result items, unpacks groups and presents them one by one.
`timescale 1ns / 1ps
module iets_back #(
	parameter int DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  iets_pkg::group_t    grp,
	output iets_pkg::link_t     lnk,
	input  logic                pop,
	output logic                empty,
	output iets_pkg::out_item_t result
);
	localparam int AW = $clog2(DEPTH);

	iets_pkg::out_item_t mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          deq;

	assign empty = (cnt_q == '0);
	assign deq = pop && !empty;
	assign result = mem[rp_q];
	assign lnk.can_take = (32'(cnt_q) <= DEPTH - 4);

	always_ff @(posedge clk) begin
		if (grp.n > 3'd0) mem[wp_q] <= grp.r0;
		if (grp.n > 3'd1) mem[wp_q + AW'(1)] <= grp.r1;
		if (grp.n > 3'd2) mem[wp_q + AW'(2)] <= grp.r2;
		if (grp.n > 3'd3) mem[wp_q + AW'(3)] <= grp.r3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + AW'(grp.n);
			rp_q <= rp_q + AW'(deq);
			cnt_q <= cnt_q + (AW+1)'(grp.n) - (AW+1)'(deq);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= DEPTH) else $error("result queue overflow");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		grp.n != 3'd0 |-> lnk.can_take) else $error("group written without room");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		deq && grp.n == 3'd0 |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not free an entry");
`endif
endmodule

[rtl/i2c_eeprom_transfer_sequencer.sv]
// Top level of the I2C EEPROM transfer sequencer.
`timescale 1ns / 1ps
// Usage:
// Input channel: drive in_item and push; an item is taken on a clock edge
// with push high and full low. Ops are requests, data bytes and bus reports.
// Result channel: while empty is low, result holds the oldest item; pop on a
// clock edge takes it. Each input item yields zero to four result items, the
// final one flagged by last.
// Results of an item are written to the result queue on the edge that takes it.
// Throughput: one item per cycle while full is low;
// full rises when the 8-entry result queue has fewer than four free slots.
// Reset (arst_n low): sequencer idle, registers at 80 and 5 ms, queue empty.
// Receiver stall: results pile up in the queue; once it nears full, full is
// raised and input halts, with nothing dropped.
// Configuration: cfg_we with cfg_idx 0 (base address) or 1 (timeout ms).
// They must be written only while idle; the block does not enforce this.
module i2c_eeprom_transfer_sequencer #(
	parameter int PAGE_BYTES   = 128,
	parameter int BLOCK_BYTES  = 65536,
	parameter int DEVICE_BYTES = 131072,
	parameter int POLLS_PER_MS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  iets_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output iets_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [7:0]          cfg_data
);
	iets_pkg::group_t grp;
	iets_pkg::link_t  lnk;
	logic             take;

	// Accept whenever the queue can absorb a worst-case group.
	assign full = !lnk.can_take;
	assign take = push && !full;

	iets_front #(
		.PAGE_BYTES(PAGE_BYTES), .BLOCK_BYTES(BLOCK_BYTES),
		.DEVICE_BYTES(DEVICE_BYTES), .POLLS_PER_MS(POLLS_PER_MS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .take(take), .item(in_item), .grp(grp)
	);

	iets_back #(.DEPTH(8)) u_back (
		.clk(clk), .arst_n(arst_n), .grp(grp), .lnk(lnk),
		.pop(pop), .empty(empty), .result(result)
	);
endmodule

[dv/i2c_eeprom_transfer_sequencer_tb.sv]
// Self-checking testbench for the I2C EEPROM transfer sequencer.
`timescale 1ns / 1ps
module i2c_eeprom_transfer_sequencer_tb;

	localparam int PAGE   = 128;
	localparam int BLOCK  = 65536;
	localparam int DEVICE = 131072;
	localparam int POLLS  = 5;
	localparam int LIMIT  = 400000;

	// Sequencer phases as tracked by the predictor.
	typedef enum int {
		P_IDLE, P_DEV_ACK, P_AHI_ACK, P_ALO_ACK, P_WR_DATA, P_WR_DATA_ACK,
		P_POLL_ACK, P_RD_DEV_ACK, P_RD_DATA
	} seq_phase_t;

	// Transfer predictor plus the store of results still owed by the block.
	class transfer_scoreboard;
		int unsigned base_addr, timeout_ms;
		seq_phase_t  phase;
		bit          is_read;
		int unsigned cur_addr, remaining, chunk_left, polls, bytes_read;
		iets_pkg::out_item_t owed[$];
		iets_pkg::out_item_t step_out[$];
		int          errors;

		function new();
			base_addr  = iets_pkg::BASE_RESET;
			timeout_ms = iets_pkg::TIMEOUT_RESET;
			phase      = P_IDLE;
			errors     = 0;
		endfunction

		function void write_reg(logic idx, logic [7:0] val);
			if (idx == iets_pkg::REG_BASE) begin
				base_addr = val & 8'h7F;
			end else begin
				timeout_ms = (val == 0) ? 1 : val;
			end
		endfunction

		function void emit(iets_pkg::kind_t k, int unsigned b, iets_pkg::status_t s,
			int unsigned c);
			iets_pkg::out_item_t r;
			r.kind     = k;
			r.bus_byte = b[7:0];
			r.status   = s;
			r.count    = c[17:0];
			r.last     = 1'b0;
			step_out.push_back(r);
		endfunction

		function int unsigned dev_byte(int unsigned a);
			int unsigned d;
			d = base_addr;
			if (a >= BLOCK) d = d | iets_pkg::BLOCK_BIT;
			return (d << 1) & 8'hFF;
		endfunction

		function void finish_xfer(iets_pkg::status_t s);
			emit(iets_pkg::K_DONE, 0, s, bytes_read);
			phase = P_IDLE;
		endfunction

		function void open_chunk();
			int unsigned bound, page_end;
			bound = (cur_addr < BLOCK) ? BLOCK : DEVICE;
			if (!is_read) begin
				page_end = (cur_addr / PAGE + 1) * PAGE;
				if (page_end < bound) bound = page_end;
			end
			chunk_left = bound - cur_addr;
			if (chunk_left > remaining) chunk_left = remaining;
			emit(iets_pkg::K_START, 0, iets_pkg::ST_OK, 0);
			emit(iets_pkg::K_SEND, dev_byte(cur_addr), iets_pkg::ST_OK, 0);
			phase = P_DEV_ACK;
		endfunction

		function void bus_abort();
			emit(iets_pkg::K_STOP, 0, iets_pkg::ST_OK, 0);
			emit(iets_pkg::K_RECOVER, 0, iets_pkg::ST_OK, 0);
			finish_xfer(iets_pkg::ST_BUS_ERR);
		endfunction

		function void poll_once();
			emit(iets_pkg::K_START, 0, iets_pkg::ST_OK, 0);
			emit(iets_pkg::K_SEND, (base_addr << 1) & 8'hFF, iets_pkg::ST_OK, 0);
			phase = P_POLL_ACK;
		endfunction

		function void ask_byte();
			emit(chunk_left == 1 ? iets_pkg::K_RNACK : iets_pkg::K_RACK, 0,
				iets_pkg::ST_OK, 0);
			phase = P_RD_DATA;
		endfunction

		// Advance the predictor by one accepted item; report whether it mattered.
		function bit note_input(iets_pkg::in_item_t it);
			seq_phase_t  prev;
			int unsigned len;
			prev = phase;
			step_out.delete();
			case (phase)
				P_IDLE: begin
					if (it.op == iets_pkg::OP_WR_REQ || it.op == iets_pkg::OP_RD_REQ) begin
						is_read    = (it.op == iets_pkg::OP_RD_REQ);
						bytes_read = 0;
						len        = it.length;
						if (len == 0 || it.start_addr + len > DEVICE) begin
							finish_xfer(iets_pkg::ST_ADDR_ERR);
						end else begin
							cur_addr  = it.start_addr;
							remaining = len;
							open_chunk();
						end
					end
				end
				P_DEV_ACK, P_AHI_ACK, P_ALO_ACK: begin
					if (it.op == iets_pkg::OP_ACK) begin
						if (!it.ack) begin
							bus_abort();
						end else if (phase == P_DEV_ACK) begin
							emit(iets_pkg::K_SEND, (cur_addr >> 8) & 8'hFF, iets_pkg::ST_OK, 0);
							phase = P_AHI_ACK;
						end else if (phase == P_AHI_ACK) begin
							emit(iets_pkg::K_SEND, cur_addr & 8'hFF, iets_pkg::ST_OK, 0);
							phase = P_ALO_ACK;
						end else if (is_read) begin
							emit(iets_pkg::K_START, 0, iets_pkg::ST_OK, 0);
							emit(iets_pkg::K_SEND, dev_byte(cur_addr) | 1, iets_pkg::ST_OK, 0);
							phase = P_RD_DEV_ACK;
						end else begin
							phase = P_WR_DATA;
						end
					end
				end
				P_WR_DATA: begin
					if (it.op == iets_pkg::OP_WR_DATA) begin
						emit(iets_pkg::K_SEND, it.data_byte, iets_pkg::ST_OK, 0);
						chunk_left--;
						remaining--;
						cur_addr++;
						phase = P_WR_DATA_ACK;
					end
				end
				P_WR_DATA_ACK: begin
					// The ack value of a data byte is ignored.
					if (it.op == iets_pkg::OP_ACK) begin
						if (chunk_left > 0) begin
							phase = P_WR_DATA;
						end else begin
							emit(iets_pkg::K_STOP, 0, iets_pkg::ST_OK, 0);
							polls = 0;
							poll_once();
						end
					end
				end
				P_POLL_ACK: begin
					if (it.op == iets_pkg::OP_ACK) begin
						emit(iets_pkg::K_STOP, 0, iets_pkg::ST_OK, 0);
						if (it.ack) begin
							if (remaining == 0) finish_xfer(iets_pkg::ST_OK);
							else open_chunk();
						end else begin
							polls++;
							if (polls >= timeout_ms * POLLS) finish_xfer(iets_pkg::ST_BUS_ERR);
							else poll_once();
						end
					end
				end
				P_RD_DEV_ACK: begin
					if (it.op == iets_pkg::OP_ACK) begin
						if (!it.ack) bus_abort();
						else ask_byte();
					end
				end
				P_RD_DATA: begin
					if (it.op == iets_pkg::OP_RD_DATA) begin
						emit(iets_pkg::K_DATA, it.data_byte, iets_pkg::ST_OK, 0);
						chunk_left--;
						remaining--;
						cur_addr++;
						bytes_read++;
						if (chunk_left > 0) begin
							ask_byte();
						end else begin
							emit(iets_pkg::K_STOP, 0, iets_pkg::ST_OK, 0);
							if (remaining == 0) finish_xfer(iets_pkg::ST_OK);
							else open_chunk();
						end
					end
				end
				default: phase = P_IDLE;
			endcase
			if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
			foreach (step_out[i]) owed.push_back(step_out[i]);
			return (step_out.size() > 0) || (phase != prev);
		endfunction

		function void check_result(iets_pkg::out_item_t got);
			iets_pkg::out_item_t want;
			if (owed.size() == 0) begin
				$error("unexpected result: kind %0d byte %0h", got.kind, got.bus_byte);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.bus_byte !== want.bus_byte) begin
				$error("bus_byte: expected %0h, actual %0h", want.bus_byte, got.bus_byte);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("count: expected %0d, actual %0d", want.count, got.count);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	iets_pkg::in_item_t  in_item;
	logic        empty;
	logic        pop;
	iets_pkg::out_item_t result;
	logic        cfg_we;
	logic        cfg_idx;
	logic [7:0]  cfg_data;

	transfer_scoreboard sb;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_req;
	bit          stubborn_polls;
	bit          refuse_dev_ack;
	iets_pkg::in_item_t directed_reqs[$];
	int          cycles;

	i2c_eeprom_transfer_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if it stalls far beyond the slowest correct run.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: check on the rising edge, decide the next pop on the falling edge.
	initial begin
		int hold_left;
		hold_left = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) sb.check_result(result);
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Pick a start address near a page or block edge most of the time.
	function automatic iets_pkg::in_item_t random_request();
		iets_pkg::in_item_t it;
		int unsigned a, len;
		it           = '0;
		it.op        = ($urandom_range(0, 1) != 0) ? iets_pkg::OP_RD_REQ : iets_pkg::OP_WR_REQ;
		it.data_byte = 8'($urandom);
		it.ack       = 1'($urandom);
		case ($urandom_range(0, 3))
			0: a = $urandom_range(0, DEVICE - 1);
			1: a = ($urandom_range(1, 1023) * PAGE) - $urandom_range(1, 3);
			2: a = BLOCK - $urandom_range(1, 4);
			default: a = DEVICE - $urandom_range(1, 6);
		endcase
		len = $urandom_range(1, 6);
		case ($urandom_range(0, 19))
			0: len = 0;
			1: len = DEVICE - a + $urandom_range(1, 5);
			default: ;
		endcase
		// Keep in-range transfers short: run to the top only from near the top.
		if (a + len > DEVICE && DEVICE - a <= 8 && $urandom_range(0, 3) != 0) len = DEVICE - a;
		it.start_addr = 17'(a);
		it.length     = 18'(len);
		return it;
	endfunction

	// Next item: mostly what the current phase waits for, sometimes noise.
	function automatic iets_pkg::in_item_t next_item();
		iets_pkg::in_item_t it;
		it            = '0;
		it.start_addr = 17'($urandom);
		it.length     = 18'($urandom_range(0, DEVICE));
		it.data_byte  = 8'($urandom);
		it.ack        = 1'($urandom);
		if (sb.phase == P_IDLE && directed_reqs.size() > 0) begin
			it = directed_reqs.pop_front();
		end else if (!refuse_dev_ack && $urandom_range(0, 99) < 8) begin
			// Noise; never start an unbounded transfer from idle.
			it.op = 3'($urandom_range(1, 7));
			if (it.op == iets_pkg::OP_RD_REQ) it.op = 3'd6;
		end else begin
			case (sb.phase)
				P_IDLE: begin
					it = random_request();
					stubborn_polls = (sb.timeout_ms <= 5) && ($urandom_range(0, 3) == 0);
				end
				P_DEV_ACK: begin
					it.op  = iets_pkg::OP_ACK;
					it.ack = ($urandom_range(0, 19) != 0) && !refuse_dev_ack;
					refuse_dev_ack = 1'b0;
				end
				P_AHI_ACK, P_ALO_ACK, P_RD_DEV_ACK: begin
					it.op  = iets_pkg::OP_ACK;
					it.ack = ($urandom_range(0, 19) != 0);
				end
				P_WR_DATA:     it.op = iets_pkg::OP_WR_DATA;
				P_WR_DATA_ACK: it.op = iets_pkg::OP_ACK;
				P_POLL_ACK: begin
					it.op  = iets_pkg::OP_ACK;
					it.ack = !stubborn_polls && ($urandom_range(0, 2) != 0);
				end
				default:       it.op = iets_pkg::OP_RD_DATA;
			endcase
		end
		return it;
	endfunction

	// Offer one item and hold it until the block takes it.
	task automatic send_item(iets_pkg::in_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push    <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		void'(sb.note_input(it));
	endtask

	// Run until enough items counted and the sequencer is back to idle.
	task automatic run_items(int target);
		int       done_cnt;
		iets_pkg::in_item_t it;
		done_cnt = 0;
		while (done_cnt < target || sb.phase != P_IDLE || directed_reqs.size() > 0) begin
			it = next_item();
			send_item(it);
			done_cnt++;
		end
		@(negedge clk);
		push <= 1'b0;
	endtask

	// Drain all owed results, let the pipeline settle, then write both registers.
	task automatic set_regs(logic [7:0] base_val, logic [7:0] tmo_val);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= iets_pkg::REG_BASE;
		cfg_data <= base_val;
		@(negedge clk);
		sb.write_reg(iets_pkg::REG_BASE, base_val);
		cfg_idx  <= iets_pkg::REG_TIMEOUT;
		cfg_data <= tmo_val;
		@(negedge clk);
		sb.write_reg(iets_pkg::REG_TIMEOUT, tmo_val);
		cfg_we   <= 1'b0;
	endtask

	function automatic iets_pkg::in_item_t req(iets_pkg::op_code_t op, int unsigned a,
		int unsigned len);
		iets_pkg::in_item_t it;
		it.op         = op;
		it.start_addr = 17'(a);
		it.length     = 18'(len);
		it.data_byte  = 8'hFF;
		it.ack        = 1'b1;
		return it;
	endfunction

	initial begin
		iets_pkg::in_item_t noise;
		sb             = new();
		push           = 1'b0;
		in_item        = '0;
		cfg_we         = 1'b0;
		cfg_idx        = iets_pkg::REG_BASE;
		cfg_data       = '0;
		hold_req       = 1'b0;
		stubborn_polls = 1'b0;
		refuse_dev_ack = 1'b0;
		send_idle_pct  = 28;
		recv_idle_pct  = 74;
		arst_n         = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: page split, block split, top address, bad lengths, ignored ops.
		noise    = '0;
		noise.op = 3'd7;
		directed_reqs.push_back(noise);
		directed_reqs.push_back(req(iets_pkg::OP_WR_REQ, 17'h0007E, 4));
		directed_reqs.push_back(req(iets_pkg::OP_RD_REQ, 17'h0FFFE, 4));
		directed_reqs.push_back(req(iets_pkg::OP_WR_REQ, 17'h1FFFF, 1));
		directed_reqs.push_back(req(iets_pkg::OP_RD_REQ, 17'h1FFFF, 1));
		directed_reqs.push_back(req(iets_pkg::OP_WR_REQ, 17'h00000, 0));
		directed_reqs.push_back(req(iets_pkg::OP_RD_REQ, 17'h1FFFF, 2));
		directed_reqs.push_back(req(iets_pkg::OP_WR_REQ, 17'h00001, DEVICE));
		run_items(15);
		// Whole-device read, cut short by a refused device ack.
		refuse_dev_ack = 1'b1;
		directed_reqs.push_back(req(iets_pkg::OP_RD_REQ, 17'h00000, DEVICE));
		run_items(1);
		run_items(30);

		// Swap idling; lowest address, zero timeout (becomes one).
		set_regs(8'h00, 8'h00);
		send_idle_pct = 74;
		recv_idle_pct = 28;
		run_items(30);

		// No idling; highest settings, and a long receiver hold to fill the queue.
		set_regs(8'h7F, 8'hFF);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = 1'b1;
		run_items(30);

		while (sb.owed.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
